[design/second_difference_limiter_defines.svh]
// assertion macros used by the checker file of the limiter
`ifndef SECOND_DIFFERENCE_LIMITER_DEFINES_SVH
`define SECOND_DIFFERENCE_LIMITER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SDL_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SDL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sdl_pkg.sv]
// types, constants and microprogram of the second difference limiter
package sdl_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int STATE_W   = 48;
  localparam int MAG_W     = 32;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 3;
  localparam int K_W       = 25;
  localparam int OPA_W     = 25;
  localparam int PROD_W    = 50;
  localparam int ACC_W     = 74;
  localparam int D2_W      = 51;
  localparam int MAGF_W    = D2_W - 1;
  localparam int LIM_W     = 32;
  localparam int HALF_W    = 24;
  localparam int PC_W      = 5;

  localparam logic [16:0] UNITY_Q16     = 17'h10000;
  localparam logic [16:0] CAP_RESET     = 17'd65536;
  localparam logic [15:0] THR_RESET     = 16'd32768;
  localparam logic [16:0] DAMP_RESET    = 17'd65536;
  localparam logic [16:0] SMOOTH_RESET  = 17'd0;
  localparam logic [24:0] GAIN_RESET    = 25'd65536;
  localparam logic [22:0] IGAIN_RESET   = 23'd65536;

  typedef struct packed {
    logic                       chan;
    logic signed [SAMPLE_W-1:0] in_sample;
  } in_beat_t;

  typedef struct packed {
    logic                       out_chan;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic [MAG_W-1:0]           second_diff_mag;
  } out_beat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAP_LEVEL     = 3'd0,
    REG_THRESHOLD     = 3'd1,
    REG_INV_DAMP      = 3'd2,
    REG_SMOOTH_WEIGHT = 3'd3,
    REG_GAIN          = 3'd4,
    REG_INV_GAIN      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [LIM_W-1:0] lim;
    logic [24:0]      gain;
    logic [16:0]      inv_damp;
    logic [16:0]      w;
    logic [16:0]      wc;
    logic [22:0]      inv_gain;
  } cfg_view_t;

  typedef enum logic [2:0] {MS_X, MS_T, MS_DI, MS_D, MS_R} mul_src_t;
  typedef enum logic [2:0] {KS_GAIN, KS_DAMP, KS_W, KS_WC, KS_IGAIN} k_sel_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD_HI} acc_op_t;
  typedef enum logic [1:0] {SH_8, SH_16, SH_24} sh_sel_t;
  typedef enum logic [3:0] {
    DST_NONE, DST_CAPTURE, DST_G, DST_D2DI, DST_MAG, DST_T, DST_R_SCALED,
    DST_R_G, DST_D, DST_M1, DST_R_MIX, DST_OUT
  } dst_t;
  typedef enum logic [2:0] {
    J_NEXT, J_ALWAYS, J_IF_NOT_OVER, J_IF_EQ, J_WAIT_IN, J_WAIT_OUT
  } jmp_t;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    mul_src_t mul_src;
    logic     mul_hi;
    k_sel_t   k_sel;
    acc_op_t  acc_op;
    sh_sel_t  sh_sel;
    dst_t     dst;
    jmp_t     jmp;
    pc_t      target;
  } ucode_t;

  typedef struct packed {
    logic over;
    logic d_eq_di;
    logic out_free;
  } dp_status_t;

  // program steps
  localparam pc_t PC_IDLE        = 5'd0;
  localparam pc_t PC_G_MUL       = 5'd1;
  localparam pc_t PC_G_LOAD      = 5'd2;
  localparam pc_t PC_G_SCALE     = 5'd3;
  localparam pc_t PC_D2          = 5'd4;
  localparam pc_t PC_MAG         = 5'd5;
  localparam pc_t PC_CLAMP       = 5'd6;
  localparam pc_t PC_DAMP_LO     = 5'd7;
  localparam pc_t PC_DAMP_HI     = 5'd8;
  localparam pc_t PC_DAMP_ADD    = 5'd9;
  localparam pc_t PC_DAMP_SCALE  = 5'd10;
  localparam pc_t PC_PASS        = 5'd11;
  localparam pc_t PC_SLOPE       = 5'd12;
  localparam pc_t PC_BLEND_CHK   = 5'd13;
  localparam pc_t PC_BLEND_DI_HI = 5'd14;
  localparam pc_t PC_BLEND_D_LO  = 5'd15;
  localparam pc_t PC_BLEND_D_HI  = 5'd16;
  localparam pc_t PC_BLEND_ADD   = 5'd17;
  localparam pc_t PC_BLEND_SUM   = 5'd18;
  localparam pc_t PC_OUT_LO      = 5'd19;
  localparam pc_t PC_OUT_HI      = 5'd20;
  localparam pc_t PC_OUT_ADD     = 5'd21;
  localparam pc_t PC_OUT         = 5'd22;

  function automatic ucode_t uword(mul_src_t ms, logic hi, k_sel_t ks, acc_op_t ao,
                                   sh_sel_t sh, dst_t ds, jmp_t jp, pc_t tg);
    ucode_t w;
    w.mul_src = ms;
    w.mul_hi  = hi;
    w.k_sel   = ks;
    w.acc_op  = ao;
    w.sh_sel  = sh;
    w.dst     = ds;
    w.jmp     = jp;
    w.target  = tg;
    return w;
  endfunction

  // control store: one word per step
  function automatic ucode_t ucode_rom(pc_t pc);
    ucode_t w;
    case (pc)
      PC_IDLE:        w = uword(MS_X, 1'b0, KS_GAIN, ACC_HOLD, SH_8, DST_CAPTURE,
                                J_WAIT_IN, PC_IDLE);
      PC_G_MUL:       w = uword(MS_X, 1'b0, KS_GAIN, ACC_HOLD, SH_8, DST_NONE,
                                J_NEXT, PC_IDLE);
      PC_G_LOAD:      w = uword(MS_X, 1'b0, KS_GAIN, ACC_LOAD, SH_8, DST_NONE,
                                J_NEXT, PC_IDLE);
      PC_G_SCALE:     w = uword(MS_X, 1'b0, KS_GAIN, ACC_HOLD, SH_8, DST_G,
                                J_NEXT, PC_IDLE);
      PC_D2:          w = uword(MS_X, 1'b0, KS_GAIN, ACC_HOLD, SH_8, DST_D2DI,
                                J_NEXT, PC_IDLE);
      PC_MAG:         w = uword(MS_X, 1'b0, KS_GAIN, ACC_HOLD, SH_8, DST_MAG,
                                J_NEXT, PC_IDLE);
      PC_CLAMP:       w = uword(MS_X, 1'b0, KS_GAIN, ACC_HOLD, SH_8, DST_T,
                                J_IF_NOT_OVER, PC_PASS);
      PC_DAMP_LO:     w = uword(MS_T, 1'b0, KS_DAMP, ACC_HOLD, SH_16, DST_NONE,
                                J_NEXT, PC_IDLE);
      PC_DAMP_HI:     w = uword(MS_T, 1'b1, KS_DAMP, ACC_LOAD, SH_16, DST_NONE,
                                J_NEXT, PC_IDLE);
      PC_DAMP_ADD:    w = uword(MS_T, 1'b1, KS_DAMP, ACC_ADD_HI, SH_16, DST_NONE,
                                J_NEXT, PC_IDLE);
      PC_DAMP_SCALE:  w = uword(MS_T, 1'b0, KS_DAMP, ACC_HOLD, SH_16, DST_R_SCALED,
                                J_ALWAYS, PC_SLOPE);
      PC_PASS:        w = uword(MS_T, 1'b0, KS_DAMP, ACC_HOLD, SH_16, DST_R_G,
                                J_NEXT, PC_IDLE);
      PC_SLOPE:       w = uword(MS_DI, 1'b0, KS_W, ACC_HOLD, SH_16, DST_D,
                                J_NEXT, PC_IDLE);
      PC_BLEND_CHK:   w = uword(MS_DI, 1'b0, KS_W, ACC_HOLD, SH_16, DST_NONE,
                                J_IF_EQ, PC_OUT_LO);
      PC_BLEND_DI_HI: w = uword(MS_DI, 1'b1, KS_W, ACC_LOAD, SH_16, DST_NONE,
                                J_NEXT, PC_IDLE);
      PC_BLEND_D_LO:  w = uword(MS_D, 1'b0, KS_WC, ACC_ADD_HI, SH_16, DST_NONE,
                                J_NEXT, PC_IDLE);
      PC_BLEND_D_HI:  w = uword(MS_D, 1'b1, KS_WC, ACC_LOAD, SH_16, DST_M1,
                                J_NEXT, PC_IDLE);
      PC_BLEND_ADD:   w = uword(MS_D, 1'b1, KS_WC, ACC_ADD_HI, SH_16, DST_NONE,
                                J_NEXT, PC_IDLE);
      PC_BLEND_SUM:   w = uword(MS_D, 1'b0, KS_WC, ACC_HOLD, SH_16, DST_R_MIX,
                                J_NEXT, PC_IDLE);
      PC_OUT_LO:      w = uword(MS_R, 1'b0, KS_IGAIN, ACC_HOLD, SH_24, DST_NONE,
                                J_NEXT, PC_IDLE);
      PC_OUT_HI:      w = uword(MS_R, 1'b1, KS_IGAIN, ACC_LOAD, SH_24, DST_NONE,
                                J_NEXT, PC_IDLE);
      PC_OUT_ADD:     w = uword(MS_R, 1'b1, KS_IGAIN, ACC_ADD_HI, SH_24, DST_NONE,
                                J_NEXT, PC_IDLE);
      PC_OUT:         w = uword(MS_R, 1'b0, KS_IGAIN, ACC_HOLD, SH_24, DST_OUT,
                                J_WAIT_OUT, PC_IDLE);
      default:        w = uword(MS_X, 1'b0, KS_GAIN, ACC_HOLD, SH_8, DST_NONE,
                                J_ALWAYS, PC_IDLE);
    endcase
    return w;
  endfunction

endpackage

[design/sdl_cfg_regs.sv]
// configuration registers and the values derived from them
module sdl_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sdl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sdl_pkg::CFG_W-1:0]       cfg_wdata,
  output sdl_pkg::cfg_view_t              cfg_view
);

  logic [16:0] cap_r, cap_nxt;
  logic [15:0] thr_r, thr_nxt;
  logic [16:0] damp_r, damp_nxt;
  logic [16:0] smooth_r, smooth_nxt;
  logic [24:0] gain_r, gain_nxt;
  logic [22:0] igain_r, igain_nxt;
  logic [sdl_pkg::LIM_W-1:0] lim_r, lim_nxt;
  logic [32:0] cap_thr;
  logic [16:0] w_sat;

  always_comb begin
    cap_nxt    = cap_r;
    thr_nxt    = thr_r;
    damp_nxt   = damp_r;
    smooth_nxt = smooth_r;
    gain_nxt   = gain_r;
    igain_nxt  = igain_r;
    if (cfg_we) begin
      case (cfg_index)
        sdl_pkg::REG_CAP_LEVEL:     cap_nxt    = cfg_wdata[16:0];
        sdl_pkg::REG_THRESHOLD:     thr_nxt    = cfg_wdata[15:0];
        sdl_pkg::REG_INV_DAMP:      damp_nxt   = cfg_wdata[16:0];
        sdl_pkg::REG_SMOOTH_WEIGHT: smooth_nxt = cfg_wdata[16:0];
        sdl_pkg::REG_GAIN:          gain_nxt   = cfg_wdata[24:0];
        sdl_pkg::REG_INV_GAIN:      igain_nxt  = cfg_wdata[22:0];
        default: ;
      endcase
    end
  end

  // limit = cap * threshold / 2, refreshed every cycle
  assign cap_thr = 33'(cap_r) * 33'(thr_r);
  assign lim_nxt = cap_thr[32:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= sdl_pkg::CAP_RESET;
      thr_r    <= sdl_pkg::THR_RESET;
      damp_r   <= sdl_pkg::DAMP_RESET;
      smooth_r <= sdl_pkg::SMOOTH_RESET;
      gain_r   <= sdl_pkg::GAIN_RESET;
      igain_r  <= sdl_pkg::IGAIN_RESET;
      lim_r    <= '0;
    end else begin
      cap_r    <= cap_nxt;
      thr_r    <= thr_nxt;
      damp_r   <= damp_nxt;
      smooth_r <= smooth_nxt;
      gain_r   <= gain_nxt;
      igain_r  <= igain_nxt;
      lim_r    <= lim_nxt;
    end
  end

  assign w_sat = (smooth_r > sdl_pkg::UNITY_Q16) ? sdl_pkg::UNITY_Q16 : smooth_r;

  assign cfg_view.lim      = lim_r;
  assign cfg_view.gain     = gain_r;
  assign cfg_view.inv_damp = damp_r;
  assign cfg_view.w        = w_sat;
  assign cfg_view.wc       = sdl_pkg::UNITY_Q16 - w_sat;
  assign cfg_view.inv_gain = igain_r;

endmodule

[design/sdl_sequencer.sv]
// step counter and control store lookup
module sdl_sequencer (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  sdl_pkg::dp_status_t     status,
  output sdl_pkg::ucode_t         uc,
  output logic                    idle
);

  sdl_pkg::pc_t    pc_r, pc_nxt;
  sdl_pkg::ucode_t word;
  sdl_pkg::pc_t    pc_inc;

  assign word   = sdl_pkg::ucode_rom(pc_r);
  assign pc_inc = pc_r + sdl_pkg::pc_t'(1);

  // next step
  always_comb begin
    case (word.jmp)
      sdl_pkg::J_NEXT:        pc_nxt = pc_inc;
      sdl_pkg::J_ALWAYS:      pc_nxt = word.target;
      sdl_pkg::J_IF_NOT_OVER: pc_nxt = status.over ? pc_inc : word.target;
      sdl_pkg::J_IF_EQ:       pc_nxt = status.d_eq_di ? word.target : pc_inc;
      sdl_pkg::J_WAIT_IN:     pc_nxt = in_valid ? pc_inc : pc_r;
      sdl_pkg::J_WAIT_OUT:    pc_nxt = status.out_free ? word.target : pc_r;
      default:                pc_nxt = sdl_pkg::PC_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    uc   = word;
    idle = (pc_r == sdl_pkg::PC_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= sdl_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[design/sdl_datapath.sv]
// shared multiplier, accumulator, working registers, channel history and output stage
module sdl_datapath #(
  parameter int CHANNELS = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sdl_pkg::ucode_t      uc,
  input  sdl_pkg::cfg_view_t   cfg_view,
  input  logic                 in_valid,
  input  sdl_pkg::in_beat_t    in_payload,
  input  logic                 out_stall,
  output logic                 out_valid,
  output sdl_pkg::out_beat_t   out_payload,
  output sdl_pkg::dp_status_t  status
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ST_W  = sdl_pkg::STATE_W;
  localparam int AW    = sdl_pkg::ACC_W;
  localparam int DW    = sdl_pkg::D2_W;
  localparam int MW    = sdl_pkg::MAGF_W;

  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [AW-1:0] v);
    logic [AW-ST_W:0] top_bits;
    top_bits = v[AW-1:ST_W-1];
    if (top_bits == '0 || top_bits == '1) begin
      return v[ST_W-1:0];
    end else if (v[AW-1]) begin
      return {1'b1, {(ST_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ST_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [sdl_pkg::SAMPLE_W-1:0] sat_out(
      input logic signed [ST_W-1:0] v);
    logic [ST_W-sdl_pkg::SAMPLE_W:0] top_bits;
    top_bits = v[ST_W-1:sdl_pkg::SAMPLE_W-1];
    if (top_bits == '0 || top_bits == '1) begin
      return v[sdl_pkg::SAMPLE_W-1:0];
    end else if (v[ST_W-1]) begin
      return {1'b1, {(sdl_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(sdl_pkg::SAMPLE_W-1){1'b1}}};
    end
  endfunction

  // channel history
  logic signed [ST_W-1:0] last_out_r    [CHANNELS];
  logic signed [ST_W-1:0] before_last_r [CHANNELS];
  logic signed [ST_W-1:0] last_in_r     [CHANNELS];

  // working registers
  logic signed [sdl_pkg::SAMPLE_W-1:0] x_r, x_nxt;
  logic                                chan_r, chan_nxt;
  logic [IDX_W-1:0]                    idx_r, idx_nxt;
  logic signed [ST_W-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic signed [ST_W-1:0] g_r, g_nxt, di_r, di_nxt, t_r, t_nxt;
  logic signed [ST_W-1:0] r_r, r_nxt, d_r, d_nxt, m1_r, m1_nxt;
  logic signed [DW-1:0]   d2_r, d2_nxt;
  logic [MW-1:0]          mag_r, mag_nxt;
  logic signed [sdl_pkg::PROD_W-1:0] p_r, p_nxt;
  logic signed [AW-1:0]   acc_r, acc_nxt;
  logic                   out_valid_r, out_valid_nxt;
  sdl_pkg::out_beat_t     out_r, out_nxt;

  logic [IDX_W-1:0]        idx_in;
  logic signed [ST_W-1:0]  src_v;
  logic signed [sdl_pkg::OPA_W-1:0] opa;
  logic [sdl_pkg::K_W-1:0] kval;
  logic signed [AW-1:0]    shifted;
  logic signed [ST_W-1:0]  scaled;
  logic signed [DW-1:0]    lim_s, cl, d2_neg;
  logic                    out_free, load_out;

  assign idx_in = (CHANNELS > 1) ? IDX_W'(in_payload.chan) : '0;

  // multiplier operand: full sample, or unsigned low / signed high half of a state word
  always_comb begin
    case (uc.mul_src)
      sdl_pkg::MS_T:  src_v = t_r;
      sdl_pkg::MS_DI: src_v = di_r;
      sdl_pkg::MS_D:  src_v = d_r;
      sdl_pkg::MS_R:  src_v = r_r;
      default:        src_v = t_r;
    endcase
    if (uc.mul_src == sdl_pkg::MS_X) begin
      opa = {x_r[sdl_pkg::SAMPLE_W-1], x_r};
    end else if (uc.mul_hi) begin
      opa = {src_v[ST_W-1], src_v[ST_W-1:sdl_pkg::HALF_W]};
    end else begin
      opa = {1'b0, src_v[sdl_pkg::HALF_W-1:0]};
    end
    case (uc.k_sel)
      sdl_pkg::KS_GAIN:  kval = cfg_view.gain;
      sdl_pkg::KS_DAMP:  kval = sdl_pkg::K_W'(cfg_view.inv_damp);
      sdl_pkg::KS_W:     kval = sdl_pkg::K_W'(cfg_view.w);
      sdl_pkg::KS_WC:    kval = sdl_pkg::K_W'(cfg_view.wc);
      sdl_pkg::KS_IGAIN: kval = sdl_pkg::K_W'(cfg_view.inv_gain);
      default:           kval = cfg_view.gain;
    endcase
  end

  assign p_nxt = sdl_pkg::PROD_W'(opa) * sdl_pkg::PROD_W'($signed({1'b0, kval}));

  always_comb begin
    case (uc.acc_op)
      sdl_pkg::ACC_LOAD:   acc_nxt = AW'(p_r);
      sdl_pkg::ACC_ADD_HI: acc_nxt = acc_r + (AW'(p_r) <<< sdl_pkg::HALF_W);
      default:             acc_nxt = acc_r;
    endcase
    case (uc.sh_sel)
      sdl_pkg::SH_8:  shifted = acc_r >>> 8;
      sdl_pkg::SH_16: shifted = acc_r >>> 16;
      sdl_pkg::SH_24: shifted = acc_r >>> 24;
      default:        shifted = acc_r >>> 8;
    endcase
  end

  assign scaled = sat_st(shifted);

  // signed clamp level
  assign lim_s  = DW'({1'b0, cfg_view.lim});
  assign cl     = d2_r[DW-1] ? -lim_s : lim_s;
  assign d2_neg = -d2_r;

  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (uc.dst == sdl_pkg::DST_OUT) && out_free;

  always_comb begin
    x_nxt   = x_r;
    chan_nxt = chan_r;
    idx_nxt = idx_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    c_nxt   = c_r;
    g_nxt   = g_r;
    d2_nxt  = d2_r;
    di_nxt  = di_r;
    mag_nxt = mag_r;
    t_nxt   = t_r;
    r_nxt   = r_r;
    d_nxt   = d_r;
    m1_nxt  = m1_r;
    out_nxt = out_r;
    case (uc.dst)
      sdl_pkg::DST_CAPTURE: begin
        if (in_valid) begin
          x_nxt    = in_payload.in_sample;
          chan_nxt = in_payload.chan;
          idx_nxt  = idx_in;
          a_nxt    = last_out_r[idx_in];
          b_nxt    = before_last_r[idx_in];
          c_nxt    = last_in_r[idx_in];
        end
      end
      sdl_pkg::DST_G:        g_nxt = scaled;
      sdl_pkg::DST_D2DI: begin
        d2_nxt = DW'(g_r) + DW'(b_r) - (DW'(a_r) <<< 1);
        di_nxt = sat_st(AW'(g_r) - AW'(c_r));
      end
      sdl_pkg::DST_MAG:      mag_nxt = d2_r[DW-1] ? d2_neg[MW-1:0] : d2_r[MW-1:0];
      sdl_pkg::DST_T:        t_nxt = sat_st(AW'(cl + (DW'(a_r) <<< 1) - DW'(b_r)));
      sdl_pkg::DST_R_SCALED: r_nxt = scaled;
      sdl_pkg::DST_R_G:      r_nxt = g_r;
      sdl_pkg::DST_D:        d_nxt = sat_st(AW'(r_r) - AW'(a_r));
      sdl_pkg::DST_M1:       m1_nxt = scaled;
      sdl_pkg::DST_R_MIX:    r_nxt = sat_st(AW'(a_r) + AW'(m1_r) + AW'(scaled));
      sdl_pkg::DST_OUT: begin
        if (out_free) begin
          out_nxt.out_chan        = chan_r;
          out_nxt.out_sample      = sat_out(scaled);
          out_nxt.second_diff_mag = (mag_r[MW-1:sdl_pkg::MAG_W] != '0) ? '1
                                    : mag_r[sdl_pkg::MAG_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    chan_r <= chan_nxt;
    idx_r  <= idx_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    g_r    <= g_nxt;
    d2_r   <= d2_nxt;
    di_r   <= di_nxt;
    mag_r  <= mag_nxt;
    t_r    <= t_nxt;
    r_r    <= r_nxt;
    d_r    <= d_nxt;
    m1_r   <= m1_nxt;
    p_r    <= p_nxt;
    acc_r  <= acc_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // history update when the result is loaded into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_out_r[i]    <= '0;
        before_last_r[i] <= '0;
        last_in_r[i]     <= '0;
      end
    end else if (load_out) begin
      last_out_r[idx_r]    <= r_r;
      before_last_r[idx_r] <= a_r;
      last_in_r[idx_r]     <= g_r;
    end
  end

  assign status.over     = mag_r > MW'(cfg_view.lim);
  assign status.d_eq_di  = (d_r == di_r);
  assign status.out_free = out_free;

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

[design/second_difference_limiter.sv]
// top level of the per-channel second difference limiter
//
// Per-channel audio limiter. Each input beat carries a signed 24-bit sample and
// its channel; each input beat yields exactly one output beat with the channel,
// the corrected sample (saturated to 24 bits) and the magnitude of the raw
// second difference (Q.8, saturated to 32 bits). Internally the sample is
// scaled by gain into 48-bit Q.8, compared against the channel's last two
// outputs, clamped and damped when the second difference exceeds
// cap_level * threshold / 2, blended with the raw input slope by smooth_weight,
// stored as channel history and scaled back by inv_gain.
// The beat is taken at the idle step, scaled, its second difference formed,
// clamped and damped only when over the limit, blended only when the slopes
// differ and loaded into the output register; only then is the next input
// beat taken. The microprogram runs every product through one shared 25 x 26
// multiplier, two partial products for each 48-bit operand, one control word
// per cycle except while it waits for an input beat or a free output register.
// A finished beat waits in the output register, so the next input is taken
// while it is still stalled; the sequencer only holds at its last step if a
// second result is ready before the first one left. Channel history resets
// to zero; configuration writes should only happen while the block is idle.
module second_difference_limiter #(
  parameter int CHANNELS = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input beats
  input  logic                            in_valid,
  output logic                            in_stall,
  input  sdl_pkg::in_beat_t               in_payload,
  // result beats
  output logic                            out_valid,
  input  logic                            out_stall,
  output sdl_pkg::out_beat_t              out_payload,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [sdl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sdl_pkg::CFG_W-1:0]       cfg_wdata
);

  sdl_pkg::cfg_view_t  cfg_view;
  sdl_pkg::ucode_t     uc;
  sdl_pkg::dp_status_t status;
  logic                idle;

  // register file plus derived limit and blend weights
  sdl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_view  (cfg_view)
  );

  // step counter walking the control store
  sdl_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .uc       (uc),
    .idle     (idle)
  );

  // multiplier, accumulator, history and output register
  sdl_datapath #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .uc          (uc),
    .cfg_view    (cfg_view),
    .in_valid    (in_valid),
    .in_payload  (in_payload),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_payload (out_payload),
    .status      (status)
  );

  // a beat is only taken at the first step of the program
  assign in_stall = !idle;

endmodule

[design/sdl_checker.sv]
// port-level checks for the limiter, bound to the top level
`include "second_difference_limiter_defines.svh"

module sdl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input sdl_pkg::in_beat_t  in_payload,
  input logic               out_valid,
  input logic               out_stall,
  input sdl_pkg::out_beat_t out_payload
);

  logic       in_acc, out_acc;
  logic [1:0] pend_r, pend_nxt;
  logic       chan_seen_r, chan_seen_nxt;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_nxt = pend_r - 2'd1;
    end
    chan_seen_nxt = in_acc ? in_payload.chan : chan_seen_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      chan_seen_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      chan_seen_r <= chan_seen_nxt;
    end
  end

  `SDL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload), "stalled result beat changed")
  `SDL_ASSERT_NEXT(a_busy_after_take, in_acc, in_stall, "input taken while an item is in work")
  `SDL_ASSERT_IMPL(a_no_extra_beat, out_valid, pend_r != 2'd0, "result beat without an input beat")
  `SDL_ASSERT_IMPL(a_chan_follows, out_valid && !($past(out_valid) && $past(out_stall)), out_payload.out_chan == chan_seen_r, "result channel differs from its input")

endmodule

bind second_difference_limiter sdl_checker u_sdl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_payload  (in_payload),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_payload (out_payload)
);

[sim/tb_second_difference_limiter.sv]
// testbench for the second difference limiter: table-driven and randomized beats vs a bit-true model
`timescale 1ns / 100ps

module tb_second_difference_limiter;

  localparam int   WATCHDOG_CYCLES = 4000;
  localparam int   HOLD_CYCLES     = 400;
  localparam int   TAIL_CYCLES     = 40;
  localparam int   RANDOM_PER_SET  = 130;
  localparam int   LAST_SET        = 7;
  localparam int   PRINT_LIMIT     = 100;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  // register widths, indexed by register code
  localparam logic [5:0][4:0] REG_BITS = {5'd23, 5'd25, 5'd17, 5'd17, 5'd16, 5'd17};

  localparam logic [23:0] SAMPLE_MAX = 24'h7FFFFF;
  localparam logic [23:0] SAMPLE_MIN = 24'h800000;
  localparam logic [23:0] SAMPLE_NEG1 = 24'hFFFFFF;

  localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint MIN48 = -MAX48 - 1;
  localparam longint OUT_MAX = 8388607;
  localparam longint OUT_MIN = -8388608;
  localparam longint MAG_MAX = 64'sd4294967295;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  sdl_pkg::in_beat_t  in_payload = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sdl_pkg::out_beat_t out_payload;
  logic                          cfg_we = 1'b0;
  logic [sdl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sdl_pkg::CFG_W-1:0]     cfg_wdata = '0;

  second_difference_limiter #(.CHANNELS(2)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_payload(out_payload),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model copy of the registers, reset values
  logic [16:0] cap_q   = 17'd65536;
  logic [15:0] thr_q   = 16'd32768;
  logic [16:0] idamp_q = 17'd65536;
  logic [16:0] sw_q    = 17'd0;
  logic [24:0] gain_q  = 25'd65536;
  logic [22:0] igain_q = 23'd65536;

  // per-channel history, Q.8
  longint hist_last [2] = '{0, 0};
  longint hist_prev [2] = '{0, 0};
  longint hist_in   [2] = '{0, 0};

  sdl_pkg::out_beat_t pending_results [$];

  int beats_sent = 0;
  int results_checked = 0;
  int settings_used = 1;
  int cap_hits = 0;
  int rail_hits = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // pacing knobs
  int  gap_pct = 0;
  int  stall_pct = 0;
  bit  hold_req = 1'b0;
  int  walk_pos [2] = '{0, 0};

  typedef struct {
    logic               chan;
    logic [23:0]        sample;
    bit                 known;
    sdl_pkg::out_beat_t want;
  } probe_row_t;

  probe_row_t probe_rows [18];

  function automatic longint clip48(input longint x);
    if (x > MAX48) return MAX48;
    if (x < MIN48) return MIN48;
    return x;
  endfunction

  // floor(x * k / 2^sh) with the operand and the result held to 48 bits
  function automatic longint scale_floor(input longint x, input longint k, input int sh);
    logic signed [95:0] prod;
    prod = clip48(x);
    prod = prod * k;
    prod = prod >>> sh;
    if (prod > MAX48) return MAX48;
    if (prod < MIN48) return MIN48;
    return longint'(prod);
  endfunction

  // one sample through the limiter, history updated
  function automatic sdl_pkg::out_beat_t limiter_step(input sdl_pkg::in_beat_t beat);
    int                 ch;
    longint             x, g, d2, mag, lim, r, di, d, w, y, a, bl, c;
    sdl_pkg::out_beat_t res;
    ch = int'(beat.chan);
    x = {{40{beat.in_sample[23]}}, beat.in_sample};
    a = hist_last[ch];
    bl = hist_prev[ch];
    c = hist_in[ch];
    g = scale_floor(x, gain_q, 8);
    d2 = g + bl - 2 * a;
    mag = (d2 < 0) ? -d2 : d2;
    lim = (longint'(cap_q) * longint'(thr_q)) >>> 1;
    r = g;
    // clamp the second difference and rebuild the output, then damp
    if (mag > lim) begin
      cap_hits++;
      r = scale_floor(((d2 < 0) ? -lim : lim) + 2 * a - bl, idamp_q, 16);
    end
    // blend output slope with raw input slope
    di = clip48(g - c);
    d = clip48(r - a);
    if (d != di) begin
      w = (sw_q > 17'd65536) ? 65536 : sw_q;
      r = clip48(a + scale_floor(di, w, 16) + scale_floor(d, 65536 - w, 16));
    end
    hist_prev[ch] = a;
    hist_last[ch] = r;
    hist_in[ch] = g;
    y = scale_floor(r, igain_q, 24);
    if (y > OUT_MAX) begin
      y = OUT_MAX;
      rail_hits++;
    end else if (y < OUT_MIN) begin
      y = OUT_MIN;
      rail_hits++;
    end
    res.out_chan = beat.chan;
    res.out_sample = y[23:0];
    res.second_diff_mag = (mag > MAG_MAX) ? '1 : mag[31:0];
    return res;
  endfunction

  // random walk with jumps, full-range noise, rails and small values
  function automatic logic [23:0] audio_like_sample(input logic ch);
    int          pick;
    int          delta;
    logic [31:0] raw;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      delta = $urandom_range(0, 1 << $urandom_range(0, 16));
      if ($urandom_range(0, 1) == 1) delta = -delta;
      walk_pos[ch] = walk_pos[ch] + delta;
      if (walk_pos[ch] > OUT_MAX) walk_pos[ch] = int'(OUT_MAX);
      if (walk_pos[ch] < OUT_MIN) walk_pos[ch] = int'(OUT_MIN);
      raw = walk_pos[ch];
    end else if (pick < 80) begin
      raw = $urandom();
    end else if (pick < 90) begin
      case ($urandom_range(0, 4))
        0: raw = 32'(SAMPLE_MAX);
        1: raw = 32'(SAMPLE_MIN);
        2: raw = 32'd0;
        3: raw = 32'(SAMPLE_NEG1);
        default: raw = 32'd1;
      endcase
    end else begin
      raw = $urandom_range(0, 510) - 255;
    end
    return raw[23:0];
  endfunction

  task automatic log_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("[%0t] mismatch on %s at result %0d: got %0d, expected %0d",
               $realtime, what, results_checked, got, want);
  endtask

  // one register write; the model takes it at the same edge
  task automatic write_reg(input logic [2:0] idx, input logic [24:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      sdl_pkg::REG_CAP_LEVEL:     cap_q = val[16:0];
      sdl_pkg::REG_THRESHOLD:     thr_q = val[15:0];
      sdl_pkg::REG_INV_DAMP:      idamp_q = val[16:0];
      sdl_pkg::REG_SMOOTH_WEIGHT: sw_q = val[16:0];
      sdl_pkg::REG_GAIN:          gain_q = val[24:0];
      sdl_pkg::REG_INV_GAIN:      igain_q = val[22:0];
      default: ;
    endcase
  endtask

  // load one register setting; junk above each register's width must be dropped
  task automatic apply_settings(input int set_no);
    logic [24:0] vals [6];
    logic [24:0] wd;
    int          i;
    case (set_no)
      1: begin  // bottom of every range, cap zero so almost everything clamps
        vals[sdl_pkg::REG_CAP_LEVEL]     = 25'd0;
        vals[sdl_pkg::REG_THRESHOLD]     = 25'd0;
        vals[sdl_pkg::REG_INV_DAMP]      = 25'd21845;
        vals[sdl_pkg::REG_SMOOTH_WEIGHT] = 25'd0;
        vals[sdl_pkg::REG_GAIN]          = 25'd655;
        vals[sdl_pkg::REG_INV_GAIN]      = 25'd164;
      end
      2: begin  // top of every range
        vals[sdl_pkg::REG_CAP_LEVEL]     = 25'd65536;
        vals[sdl_pkg::REG_THRESHOLD]     = 25'd32768;
        vals[sdl_pkg::REG_INV_DAMP]      = 25'd65536;
        vals[sdl_pkg::REG_SMOOTH_WEIGHT] = 25'd65536;
        vals[sdl_pkg::REG_GAIN]          = 25'd26214400;
        vals[sdl_pkg::REG_INV_GAIN]      = 25'd6553600;
      end
      3: begin  // all ones, smooth weight above unity
        vals[sdl_pkg::REG_CAP_LEVEL]     = 25'h1FFFF;
        vals[sdl_pkg::REG_THRESHOLD]     = 25'hFFFF;
        vals[sdl_pkg::REG_INV_DAMP]      = 25'h1FFFF;
        vals[sdl_pkg::REG_SMOOTH_WEIGHT] = 25'h1FFFF;
        vals[sdl_pkg::REG_GAIN]          = 25'h1FFFFFF;
        vals[sdl_pkg::REG_INV_GAIN]      = 25'h7FFFFF;
      end
      5: begin  // damp gain near two with a low cap: history runs into 48-bit rails
        vals[sdl_pkg::REG_CAP_LEVEL]     = 25'd2000;
        vals[sdl_pkg::REG_THRESHOLD]     = 25'd30000;
        vals[sdl_pkg::REG_INV_DAMP]      = 25'h1FFFF;
        vals[sdl_pkg::REG_SMOOTH_WEIGHT] = 25'd0;
        vals[sdl_pkg::REG_GAIN]          = 25'd65536;
        vals[sdl_pkg::REG_INV_GAIN]      = 25'd65536;
      end
      6: begin  // anything the register widths allow
        for (i = 0; i < 6; i++) vals[i] = 25'($urandom());
      end
      default: begin  // random within the stated ranges, mostly modest gains
        vals[sdl_pkg::REG_CAP_LEVEL]     = 25'($urandom_range(0, 65536));
        vals[sdl_pkg::REG_THRESHOLD]     = 25'($urandom_range(0, 32768));
        vals[sdl_pkg::REG_INV_DAMP]      = 25'($urandom_range(21845, 65536));
        vals[sdl_pkg::REG_SMOOTH_WEIGHT] = 25'($urandom_range(0, 65536));
        vals[sdl_pkg::REG_GAIN] = ($urandom_range(0, 3) == 0)
                                  ? 25'($urandom_range(655, 26214400))
                                  : 25'($urandom_range(655, 131072));
        vals[sdl_pkg::REG_INV_GAIN] = ($urandom_range(0, 3) == 0)
                                      ? 25'($urandom_range(164, 6553600))
                                      : 25'($urandom_range(164, 131072));
      end
    endcase
    for (i = 0; i < 6; i++) begin
      wd = 25'($urandom());
      wd = (wd << REG_BITS[i]) | vals[i];
      write_reg(i[2:0], wd);
    end
    // writes to unused indexes change nothing
    write_reg(REG_SPARE_A, 25'($urandom()));
    write_reg(REG_SPARE_B, 25'($urandom()));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // offer one beat and hold it until taken; the model runs on the taking edge
  task automatic offer_beat(input sdl_pkg::in_beat_t beat, input bit known,
                            input sdl_pkg::out_beat_t want);
    sdl_pkg::out_beat_t pred;
    in_payload <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = limiter_step(beat);
    pending_results.push_back(known ? want : pred);
    beats_sent++;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic pick_pacing();
    case ($urandom_range(0, 3))
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 10; stall_pct = 5;  end
      2: begin gap_pct = 35; stall_pct = 15; end
      default: begin gap_pct = 0; stall_pct = 25; end
    endcase
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // compare every taken result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    sdl_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        log_mismatch("beat with nothing pending",
                     longint'($signed(out_payload.out_sample)), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_payload.out_chan !== want.out_chan)
          log_mismatch("out_chan", longint'(out_payload.out_chan),
                       longint'(want.out_chan));
        if (out_payload.out_sample !== want.out_sample)
          log_mismatch("out_sample", longint'($signed(out_payload.out_sample)),
                       longint'($signed(want.out_sample)));
        if (out_payload.second_diff_mag !== want.second_diff_mag)
          log_mismatch("second_diff_mag", longint'(out_payload.second_diff_mag),
                       longint'(want.second_diff_mag));
        results_checked++;
      end
    end
  end

  // watchdog: too long without any beat moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_CYCLES) begin
        $display("watchdog: no beat moved for %0d cycles, %0d results still pending",
                 WATCHDOG_CYCLES, pending_results.size());
        $display("tb_second_difference_limiter: done, errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    sdl_pkg::in_beat_t  beat;
    sdl_pkg::out_beat_t none;
    int                 set_no;
    int                 k;
    none = '0;
    // reset settings: unity gain, limit 2^30, no damping, no smoothing
    probe_rows[0]  = '{1'b0, 24'd0,     1'b1, '{1'b0, 24'd0,    32'd0}};
    probe_rows[1]  = '{1'b1, 24'd0,     1'b1, '{1'b1, 24'd0,    32'd0}};
    // step up from silence, then hold: slope and curvature settle to zero
    probe_rows[2]  = '{1'b0, 24'd1000,  1'b1, '{1'b0, 24'd1000, 32'd256000}};
    probe_rows[3]  = '{1'b0, 24'd1000,  1'b1, '{1'b0, 24'd1000, 32'd256000}};
    probe_rows[4]  = '{1'b0, 24'd1000,  1'b1, '{1'b0, 24'd1000, 32'd0}};
    // rail to rail swings: clamp on both signs, channels interleaved
    probe_rows[5]  = '{1'b1, SAMPLE_MAX,  1'b0, none};
    probe_rows[6]  = '{1'b1, SAMPLE_MIN,  1'b0, none};
    probe_rows[7]  = '{1'b1, SAMPLE_MAX,  1'b0, none};
    probe_rows[8]  = '{1'b0, SAMPLE_MIN,  1'b0, none};
    probe_rows[9]  = '{1'b0, SAMPLE_NEG1, 1'b0, none};
    probe_rows[10] = '{1'b1, 24'd0,       1'b0, none};
    probe_rows[11] = '{1'b0, SAMPLE_MAX,  1'b0, none};
    probe_rows[12] = '{1'b0, SAMPLE_MAX,  1'b0, none};
    probe_rows[13] = '{1'b1, SAMPLE_MIN,  1'b0, none};
    probe_rows[14] = '{1'b1, SAMPLE_MIN,  1'b0, none};
    probe_rows[15] = '{1'b0, 24'd1,       1'b0, none};
    probe_rows[16] = '{1'b1, 24'h555555,  1'b0, none};
    probe_rows[17] = '{1'b0, 24'hAAAAAA,  1'b0, none};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (set_no = 0; set_no <= LAST_SET; set_no++) begin
      if (set_no != 0) apply_settings(set_no);
      pick_pacing();
      if (set_no == 0) begin
        foreach (probe_rows[p]) begin
          beat.chan = probe_rows[p].chan;
          beat.in_sample = probe_rows[p].sample;
          offer_beat(beat, probe_rows[p].known, probe_rows[p].want);
        end
      end
      for (k = 0; k < RANDOM_PER_SET; k++) begin
        if (k % 40 == 0) pick_pacing();
        // final stretch runs flat out on both sides
        if (set_no == LAST_SET) begin
          gap_pct = 0;
          stall_pct = 0;
        end
        // one long receiver hold-off while beats keep coming
        if (set_no == 4 && k == 25) hold_req = 1'b1;
        beat.chan = 1'($urandom_range(0, 1));
        beat.in_sample = audio_like_sample(beat.chan);
        offer_beat(beat, 1'b0, none);
      end
      in_valid <= 1'b0;
      wait_for_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d sample beats over %0d register settings, %0d results compared",
             beats_sent, settings_used, results_checked);
    $display("%0d beats went through the second-difference clamp, %0d hit the output rail",
             cap_hits, rail_hits);
    if (mismatches == 0)
      $display("tb_second_difference_limiter: done, clean");
    else
      $display("tb_second_difference_limiter: done, errors");
    $finish;
  end

endmodule
